FILE: rtl/core/dbcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-byte code set package
// Shared widths, the cell command bundle and elaboration-time helpers for
// sizing the registered reduction tree.
// ----------------------------------------------------------------------------
package dbcs_pkg;

   // Field widths fixed by the interface.
   localparam int CODE_W  = 16;
   localparam int BYTE_W  = 8;
   localparam int IDX_W   = 10;
   localparam int ENTRY_W = 11;

   // One tree leaf carries an equality flag above a masked entry value.
   localparam int LEAF_W = CODE_W + 1;

   // Default table depth and fan-in of each reduction tree node.
   localparam int TABLE_DEPTH_DEF = 1024;
   localparam int TREE_FAN        = 32;

   // Highest single-byte (ASCII) value; anything above it opens a pair.
   localparam logic [BYTE_W-1:0] ASCII_MAX = 8'h7F;

   // Command broadcast from the controller to every cell of the chain.
   typedef struct packed {
      logic              insert;
      logic [CODE_W-1:0] code;
      logic [IDX_W-1:0]  read_idx;
   } cell_cmd_type;

   // Integer power, used only while elaborating.
   function automatic int pow_int(input int base, input int exp);
      int result;
      result = 1;
      for (int k = 0; k < exp; k++) begin
         result = result * base;
      end
      return result;
   endfunction

   // Number of registered levels needed to reduce the given leaf count.
   function automatic int tree_levels(input int leaves, input int fan);
      int levels;
      int span;
      levels = 1;
      span   = fan;
      for (int k = 0; k < 32; k++) begin
         if (span < leaves) begin
            levels = levels + 1;
            span   = span * fan;
         end
      end
      return levels;
   endfunction

   // Start of a level in the flat node array (level 1 starts at zero).
   function automatic int level_offset(input int level, input int levels, input int fan);
      int offset;
      offset = 0;
      for (int k = 1; k < level; k++) begin
         offset = offset + pow_int(fan, levels - k);
      end
      return offset;
   endfunction

endpackage

FILE: rtl/core/dbcs_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted chain cell
// Holds one table entry. On an insert it either keeps its entry, takes the
// entry of its left neighbour or takes the new code, so the chain shifts
// right by one place from the insertion point.
// ----------------------------------------------------------------------------
module dbcs_cell
   import dbcs_pkg::*;
#(
   parameter int INDEX = 0,
   parameter int CNT_W = 11
) (
   input  logic              clock,
   input  cell_cmd_type      cmd,
   input  logic [CNT_W-1:0]  count,
   input  logic [CODE_W-1:0] prev_value,
   input  logic              prev_move,
   output logic [CODE_W-1:0] value,
   output logic              move,
   output logic [LEAF_W-1:0] leaf
);

   localparam int CMP_W = (IDX_W > CNT_W) ? IDX_W : CNT_W;

   logic [CODE_W-1:0] value_ff;
   logic [CODE_W-1:0] value_in;
   logic              occupied;
   logic              at_tail;
   logic              hit;

   // Position of this cell relative to the fill level.
   assign occupied = (count > CNT_W'(INDEX));
   assign at_tail  = (count == CNT_W'(INDEX));
   assign hit      = occupied && (CMP_W'(cmd.read_idx) == CMP_W'(INDEX));

   // A cell moves when its entry is larger than the new code, or when it is
   // the first free place and nothing larger exists.
   assign move = occupied ? (value_ff > cmd.code) : at_tail;

   // Leaf for the reduction tree: equality flag and the addressed entry.
   assign leaf = {occupied && (value_ff == cmd.code), (hit ? value_ff : {CODE_W{1'b0}})};

   // Next entry: shift in the neighbour's entry or the new code.
   always_comb begin
      value_in = value_ff;
      if (cmd.insert && move) begin
         value_in = prev_move ? prev_value : cmd.code;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

FILE: rtl/core/dbcs_or_tree.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Registered OR reduction tree
// Folds the leaves of the cell chain into one word through registered levels
// of FAN-input OR gates.
// ----------------------------------------------------------------------------
module dbcs_or_tree
   import dbcs_pkg::*;
#(
   parameter int LEAVES = TABLE_DEPTH_DEF,
   parameter int WIDTH  = LEAF_W,
   parameter int FAN    = TREE_FAN
) (
   input  logic                          clock,
   input  logic [LEAVES-1:0][WIDTH-1:0]  leaf,
   output logic [WIDTH-1:0]              root
);

   localparam int LEVELS  = tree_levels(LEAVES, FAN);
   localparam int PADDED  = pow_int(FAN, LEVELS);
   localparam int NODES   = level_offset(LEVELS + 1, LEVELS, FAN);
   localparam int BASE_IW = $clog2(PADDED);
   localparam int NODE_IW = (NODES > 1) ? $clog2(NODES) : 1;

   logic [WIDTH-1:0] base    [PADDED];
   logic [WIDTH-1:0] node_ff [NODES];

   // Pad the leaf row to a full power of the fan-in.
   for (genvar p = 0; p < PADDED; p++) begin : g_pad
      if (p < LEAVES) begin : g_leaf
         assign base[p] = leaf[p];
      end else begin : g_zero
         assign base[p] = '0;
      end
   end

   // One registered level per pass of the loop.
   for (genvar l = 1; l <= LEVELS; l++) begin : g_level
      localparam int COUNT = pow_int(FAN, LEVELS - l);
      localparam int OFF   = level_offset(l, LEVELS, FAN);
      localparam int POFF  = level_offset(l - 1, LEVELS, FAN);
      for (genvar j = 0; j < COUNT; j++) begin : g_node
         logic [WIDTH-1:0] node_in;
         if (l == 1) begin : g_first
            always_comb begin
               node_in = '0;
               for (int c = 0; c < FAN; c++) begin
                  node_in = node_in | base[BASE_IW'(j*FAN + c)];
               end
            end
         end else begin : g_upper
            always_comb begin
               node_in = '0;
               for (int c = 0; c < FAN; c++) begin
                  node_in = node_in | node_ff[NODE_IW'(POFF + j*FAN + c)];
               end
            end
         end
         always_ff @(posedge clock) begin
            node_ff[OFF + j] <= node_in;
         end
      end
   end

   assign root = node_ff[NODES-1];

endmodule

FILE: rtl/core/dbcs_code_sorted_set_builder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-byte code sorted set builder
// A byte that forms no code, a clear or an unused command is answered from the
// decode state; a formed code or a read first waits in the search state for the
// OR tree, ceil(log32(TABLE_DEPTH)) registered levels deep (2 here), then commits
// and answers. One item is in flight at a time, and a stalled output holds it.
// Reset clears the count, pending lead and handshake; cell entries are masked.
// ----------------------------------------------------------------------------
module dbcs_code_sorted_set_builder
   import dbcs_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_kind,
   input  logic [BYTE_W-1:0]  req_data_byte,
   input  logic               req_last_in_string,
   input  logic [IDX_W-1:0]   req_read_index,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_status,
   output logic [CODE_W-1:0]  rsp_code,
   output logic [ENTRY_W-1:0] rsp_entry_count,
   output logic [CODE_W-1:0]  rsp_read_value
);

   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int CMP_W  = (IDX_W > CNT_W) ? IDX_W : CNT_W;
   localparam int LEVELS = tree_levels(TABLE_DEPTH, TREE_FAN);
   localparam int WAIT_W = $clog2(LEVELS + 1);

   // Command kinds.
   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   // Result status codes.
   localparam logic [2:0] STATUS_NONE     = 3'd0;
   localparam logic [2:0] STATUS_INSERTED = 3'd1;
   localparam logic [2:0] STATUS_DUP      = 3'd2;
   localparam logic [2:0] STATUS_FULL     = 3'd3;
   localparam logic [2:0] STATUS_READ_OK  = 3'd4;
   localparam logic [2:0] STATUS_READ_BAD = 3'd5;
   localparam logic [2:0] STATUS_CLEARED  = 3'd6;

   // Controller states.
   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_EXEC   = 2'd1;
   localparam logic [1:0] S_SEARCH = 2'd2;

   localparam logic [WAIT_W-1:0] WAIT_START = WAIT_W'(LEVELS - 1);

   logic [1:0]         state_ff,  state_in;
   logic [WAIT_W-1:0]  wait_ff,   wait_in;
   logic [BYTE_W-1:0]  lead_ff,   lead_in;
   logic               pend_ff,   pend_in;
   logic [CNT_W-1:0]   count_ff,  count_in;

   logic [1:0]         kind_ff;
   logic [BYTE_W-1:0]  byte_ff;
   logic               last_ff;
   logic [IDX_W-1:0]   idx_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         rsp_status_ff, rsp_status_in;
   logic [CODE_W-1:0]  rsp_code_ff, rsp_code_in;
   logic [ENTRY_W-1:0] rsp_entry_ff;
   logic [CODE_W-1:0]  rsp_read_ff, rsp_read_in;

   logic               req_take;
   logic               out_free;
   logic               rsp_load;
   logic               insert_en;
   logic [CODE_W-1:0]  code_w;
   cell_cmd_type       cmd;

   logic [CODE_W-1:0]               cell_value [TABLE_DEPTH];
   logic                            cell_move  [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0][LEAF_W-1:0] cell_leaf;
   logic [LEAF_W-1:0]               tree_root;

   // Handshake: one item in flight, the output register decouples the sink.
   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // The code formed by the held lead byte and the current byte.
   assign code_w = {lead_ff, byte_ff};

   assign cmd.insert   = insert_en;
   assign cmd.code     = code_w;
   assign cmd.read_idx = idx_ff;

   // Row of cells, each handing its entry and move flag to the right.
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         dbcs_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
         ) u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .count      (count_ff),
            .prev_value ({CODE_W{1'b0}}),
            .prev_move  (1'b0),
            .value      (cell_value[i]),
            .move       (cell_move[i]),
            .leaf       (cell_leaf[i])
         );
      end else begin : g_body
         dbcs_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
         ) u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .count      (count_ff),
            .prev_value (cell_value[i-1]),
            .prev_move  (cell_move[i-1]),
            .value      (cell_value[i]),
            .move       (cell_move[i]),
            .leaf       (cell_leaf[i])
         );
      end
   end

   // Duplicate flag and read data gathered from all cells.
   dbcs_or_tree #(
      .LEAVES (TABLE_DEPTH),
      .WIDTH  (LEAF_W),
      .FAN    (TREE_FAN)
   ) u_tree (
      .clock (clock),
      .leaf  (cell_leaf),
      .root  (tree_root)
   );

   // Item register, loaded on each input transfer.
   always_ff @(posedge clock) begin
      if (req_take) begin
         kind_ff <= req_kind;
         byte_ff <= req_data_byte;
         last_ff <= req_last_in_string;
         idx_ff  <= req_read_index;
      end
   end

   // Controller: decode, wait for the tree where needed, then commit and answer.
   always_comb begin
      state_in      = state_ff;
      wait_in       = wait_ff;
      lead_in       = lead_ff;
      pend_in       = pend_ff;
      count_in      = count_ff;
      insert_en     = 1'b0;
      rsp_load      = 1'b0;
      rsp_status_in = STATUS_NONE;
      rsp_code_in   = '0;
      rsp_read_in   = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            case (kind_ff)
               KIND_BYTE: begin
                  if (pend_ff) begin
                     state_in = S_SEARCH;
                     wait_in  = WAIT_START;
                  end else if (out_free) begin
                     rsp_load = 1'b1;
                     state_in = S_IDLE;
                     if ((byte_ff > ASCII_MAX) && !last_ff) begin
                        lead_in = byte_ff;
                        pend_in = 1'b1;
                     end
                  end
               end
               KIND_READ: begin
                  state_in = S_SEARCH;
                  wait_in  = WAIT_START;
               end
               KIND_CLEAR: begin
                  if (out_free) begin
                     rsp_load      = 1'b1;
                     rsp_status_in = STATUS_CLEARED;
                     count_in      = '0;
                     pend_in       = 1'b0;
                     lead_in       = '0;
                     state_in      = S_IDLE;
                  end
               end
               default: begin
                  if (out_free) begin
                     rsp_load = 1'b1;
                     state_in = S_IDLE;
                  end
               end
            endcase
         end
         S_SEARCH: begin
            if (wait_ff != '0) begin
               wait_in = wait_ff - WAIT_W'(1);
            end else if (out_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
               if (kind_ff == KIND_READ) begin
                  if (CMP_W'(idx_ff) < CMP_W'(count_ff)) begin
                     rsp_status_in = STATUS_READ_OK;
                     rsp_read_in   = tree_root[CODE_W-1:0];
                  end else begin
                     rsp_status_in = STATUS_READ_BAD;
                  end
               end else begin
                  rsp_code_in = code_w;
                  pend_in     = 1'b0;
                  lead_in     = '0;
                  if (tree_root[LEAF_W-1]) begin
                     rsp_status_in = STATUS_DUP;
                  end else if (count_ff == CNT_W'(TABLE_DEPTH)) begin
                     rsp_status_in = STATUS_FULL;
                  end else begin
                     rsp_status_in = STATUS_INSERTED;
                     insert_en     = 1'b1;
                     count_in      = count_ff + CNT_W'(1);
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Controller state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         wait_ff  <= '0;
         lead_ff  <= '0;
         pend_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         wait_ff  <= wait_in;
         lead_ff  <= lead_in;
         pend_ff  <= pend_in;
         count_ff <= count_in;
      end
   end

   // Output register: holds a result until the sink completes its transfer.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_code_ff   <= rsp_code_in;
         rsp_entry_ff  <= ENTRY_W'(count_in);
         rsp_read_ff   <= rsp_read_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_code        = rsp_code_ff;
   assign rsp_entry_count = rsp_entry_ff;
   assign rsp_read_value  = rsp_read_ff;

   // The fill count never passes the number of cells.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
   else $error("entry count exceeds table depth");

   // An insert shifts the chain only when a free cell remains.
   assert property (@(posedge clock) disable iff (reset)
      insert_en |-> (count_ff < CNT_W'(TABLE_DEPTH)))
   else $error("insert into a full chain");

   // Every input transfer moves the controller straight to decode.
   assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == S_EXEC))
   else $error("accepted item not decoded");

   // A new result is only loaded while no unsent result would be lost.
   assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || !rsp_stall))
   else $error("result overwritten before transfer");

endmodule

FILE: tb/dbcs_code_sorted_set_builder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-byte code sorted set builder testbench
// Drives string bytes, reads, clears and unused commands into the block under
// random flow control. A model of the sorted set inside the bench predicts every
// result, and a monitor checks each result transfer field by field in order. A
// run of distinct codes in mixed order, then some of them again, covers ordered
// insertion and duplicates in a table filled from empty.
// ----------------------------------------------------------------------------
module dbcs_code_sorted_set_builder_tb
   import dbcs_pkg::*;
();

   localparam int SET_DEPTH  = TABLE_DEPTH_DEF;
   localparam int TBL_IW     = $clog2(SET_DEPTH);
   localparam int FILL_CODES = 64;

   typedef enum logic [1:0] {
      KIND_BYTE   = 2'd0,
      KIND_READ   = 2'd1,
      KIND_CLEAR  = 2'd2,
      KIND_UNUSED = 2'd3
   } cmd_kind_type;

   typedef enum logic [2:0] {
      ST_NONE      = 3'd0,
      ST_INSERTED  = 3'd1,
      ST_DUPLICATE = 3'd2,
      ST_FULL      = 3'd3,
      ST_READ_OK   = 3'd4,
      ST_READ_BAD  = 3'd5,
      ST_CLEARED   = 3'd6
   } set_status_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [BYTE_W-1:0] data;
      logic              last;
      logic [IDX_W-1:0]  idx;
   } set_cmd_type;

   typedef struct packed {
      set_status_type     status;
      logic [CODE_W-1:0]  code;
      logic [ENTRY_W-1:0] count;
      logic [CODE_W-1:0]  rval;
   } set_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_kind = KIND_BYTE;
   logic [BYTE_W-1:0]  req_data_byte = '0;
   logic               req_last_in_string = 1'b0;
   logic [IDX_W-1:0]   req_read_index = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [2:0]         rsp_status;
   logic [CODE_W-1:0]  rsp_code;
   logic [ENTRY_W-1:0] rsp_entry_count;
   logic [CODE_W-1:0]  rsp_read_value;

   // Commands waiting to be offered and results waiting to arrive.
   set_cmd_type    pending_cmds[$];
   set_result_type expected_results[$];

   int total_cmds;
   int accepted_count;
   int fail_count;
   int hold_start;

   // Bench copy of the block state.
   logic [CODE_W-1:0] code_table [SET_DEPTH];
   int                code_total;
   logic [BYTE_W-1:0] lead_byte;
   logic              lead_held;

   dbcs_code_sorted_set_builder uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_data_byte      (req_data_byte),
      .req_last_in_string (req_last_in_string),
      .req_read_index     (req_read_index),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_code           (rsp_code),
      .rsp_entry_count    (rsp_entry_count),
      .rsp_read_value     (rsp_read_value)
   );

   always #4 clock = ~clock;

   // Work out the result of one accepted command and update the bench state.
   function automatic set_result_type predict_set_result(input set_cmd_type cmd);
      set_result_type    res;
      logic [CODE_W-1:0] pair;
      int                pos;
      int                k;
      res = '{status: ST_NONE, code: '0, count: '0, rval: '0};
      case (cmd.kind)
         KIND_BYTE: begin
            if (lead_held) begin
               // The held lead and this byte form a code, whatever the byte.
               pair      = {lead_byte, cmd.data};
               lead_held = 1'b0;
               lead_byte = '0;
               res.code  = pair;
               pos       = 0;
               while (pos < code_total && code_table[TBL_IW'(pos)] < pair) begin
                  pos++;
               end
               if (pos < code_total && code_table[TBL_IW'(pos)] == pair) begin
                  res.status = ST_DUPLICATE;
               end else if (code_total >= SET_DEPTH) begin
                  res.status = ST_FULL;
               end else begin
                  for (k = code_total; k > pos; k--) begin
                     code_table[TBL_IW'(k)] = code_table[TBL_IW'(k - 1)];
                  end
                  code_table[TBL_IW'(pos)] = pair;
                  code_total++;
                  res.status = ST_INSERTED;
               end
            end else if (cmd.data > ASCII_MAX && !cmd.last) begin
               lead_byte = cmd.data;
               lead_held = 1'b1;
            end
         end
         KIND_READ: begin
            if (int'(cmd.idx) < code_total) begin
               res.status = ST_READ_OK;
               res.rval   = code_table[TBL_IW'(cmd.idx)];
            end else begin
               res.status = ST_READ_BAD;
            end
         end
         KIND_CLEAR: begin
            code_total = 0;
            lead_held  = 1'b0;
            lead_byte  = '0;
            res.status = ST_CLEARED;
         end
         default: begin
         end
      endcase
      res.count = code_total[ENTRY_W-1:0];
      return res;
   endfunction

   // Idle rates follow the progress of the run: three thirds.
   function automatic int sender_idle_pct();
      if (accepted_count < total_cmds / 3) return 32;
      if (accepted_count < 2 * total_cmds / 3) return 79;
      return 0;
   endfunction

   function automatic int receiver_idle_pct();
      if (accepted_count < total_cmds / 3) return 79;
      if (accepted_count < 2 * total_cmds / 3) return 32;
      return 0;
   endfunction

   task automatic queue_cmd(input cmd_kind_type kind, input int data, input int last,
                            input int idx);
      set_cmd_type item;
      item.kind    = kind;
      item.data    = BYTE_W'(data);
      item.last    = 1'(last);
      item.idx     = IDX_W'(idx);
      pending_cmds = {pending_cmds, item};
   endtask

   // Mostly well-formed strings with random content, plus reads, clears and noise.
   task automatic queue_random_cmds(input int count);
      int made;
      int pick;
      int chars;
      int lead;
      int trail;
      made = 0;
      while (made < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            chars = $urandom_range(1, 12);
            for (int c = 0; c < chars; c++) begin
               if ($urandom_range(0, 2) == 0) begin
                  queue_cmd(KIND_BYTE, $urandom_range(0, 127), int'(c == chars - 1),
                            $urandom);
                  made++;
               end else begin
                  // A small pool of codes makes duplicates common.
                  lead  = ($urandom_range(0, 3) == 0) ? $urandom_range(128, 255)
                                                       : 128 + $urandom_range(0, 7);
                  trail = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                       : $urandom_range(0, 15);
                  if (c == chars - 1 && $urandom_range(0, 9) == 0) begin
                     // Broken string: a lead byte that ends it.
                     queue_cmd(KIND_BYTE, lead, 1, $urandom);
                     made++;
                  end else begin
                     queue_cmd(KIND_BYTE, lead, 0, $urandom);
                     if ($urandom_range(0, 9) == 0) begin
                        queue_cmd(KIND_READ, $urandom, $urandom, $urandom_range(0, 40));
                        made++;
                     end
                     queue_cmd(KIND_BYTE, trail, int'(c == chars - 1), $urandom);
                     made += 2;
                  end
               end
            end
         end else if (pick < 85) begin
            queue_cmd(KIND_READ, $urandom, $urandom,
                      ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                  : $urandom_range(0, 40));
            made++;
         end else if (pick < 88) begin
            queue_cmd(KIND_CLEAR, $urandom, $urandom, $urandom);
            made++;
         end else if (pick < 91) begin
            queue_cmd(KIND_UNUSED, $urandom, $urandom, $urandom);
            made++;
         end else begin
            queue_cmd(KIND_BYTE, $urandom, $urandom, $urandom);
            made++;
         end
      end
   endtask

   // Driver: offers the next command once the current one has been transferred.
   always @(posedge clock) begin : cmd_driver
      set_cmd_type    cur_cmd;
      set_result_type next_res;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            next_res         = predict_set_result(cur_cmd);
            expected_results = {expected_results, next_res};
            accepted_count++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
               cur_cmd            = pending_cmds.pop_front();
               req_valid          <= 1'b1;
               req_kind           <= cur_cmd.kind;
               req_data_byte      <= cur_cmd.data;
               req_last_in_string <= cur_cmd.last;
               req_read_index     <= cur_cmd.idx;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each result transfer and drives the receiver stall.
   always @(posedge clock) begin : result_monitor
      set_result_type want;
      int             hold_left;
      bit             hold_done;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
         hold_done = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result: status %0d code %h", rsp_status, rsp_code);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_status);
                  fail_count++;
               end
               if (rsp_code !== want.code) begin
                  $error("code: expected %h, actual %h", want.code, rsp_code);
                  fail_count++;
               end
               if (rsp_entry_count !== want.count) begin
                  $error("entry_count: expected %0d, actual %0d", want.count,
                         rsp_entry_count);
                  fail_count++;
               end
               if (rsp_read_value !== want.rval) begin
                  $error("read_value: expected %h, actual %h", want.rval, rsp_read_value);
                  fail_count++;
               end
            end
         end
         // One long hold-off while the sender keeps offering, to fill the block.
         if (!hold_done && accepted_count >= hold_start) begin
            hold_left = 400;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < receiver_idle_pct());
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      int fill_pick;
      code_total     = 0;
      lead_held      = 1'b0;
      lead_byte      = '0;
      accepted_count = 0;
      fail_count     = 0;

      // Directed part: field extremes and the special cases.
      queue_cmd(KIND_READ, 'h00, 0, 0);        // read of an empty set
      queue_cmd(KIND_BYTE, 'h00, 0, 0);        // ASCII byte
      queue_cmd(KIND_BYTE, 'h7F, 1, 1023);     // highest ASCII byte
      queue_cmd(KIND_BYTE, 'h80, 1, 0);        // lead byte that ends its string
      queue_cmd(KIND_BYTE, 'h80, 0, 0);        // lead held
      queue_cmd(KIND_BYTE, 'h00, 1, 0);        // trail with end of string
      queue_cmd(KIND_BYTE, 'hFF, 0, 0);
      queue_cmd(KIND_BYTE, 'hFF, 0, 0);
      queue_cmd(KIND_BYTE, 'h81, 0, 0);
      queue_cmd(KIND_BYTE, 'h7F, 0, 0);        // ASCII value as trail
      queue_cmd(KIND_BYTE, 'hFF, 0, 0);
      queue_cmd(KIND_BYTE, 'hFF, 1, 0);        // duplicate
      queue_cmd(KIND_BYTE, 'h90, 0, 0);
      queue_cmd(KIND_READ, 'h00, 0, 1);        // read between lead and trail
      queue_cmd(KIND_BYTE, 'h40, 0, 0);
      queue_cmd(KIND_READ, 'hFF, 1, 0);
      queue_cmd(KIND_READ, 'h00, 0, 3);
      queue_cmd(KIND_READ, 'h00, 0, 4);        // first index out of range
      queue_cmd(KIND_READ, 'h00, 0, 1023);
      queue_cmd(KIND_UNUSED, 'hFF, 1, 1023);   // unused command
      queue_cmd(KIND_BYTE, 'hA0, 0, 0);
      queue_cmd(KIND_CLEAR, 'hFF, 1, 1023);    // clear drops the pending lead
      queue_cmd(KIND_BYTE, 'h41, 0, 0);
      queue_cmd(KIND_CLEAR, 'h00, 0, 0);

      queue_random_cmds(160);

      // Distinct codes in mixed order from an empty set.
      queue_cmd(KIND_CLEAR, $urandom, $urandom, $urandom);
      for (int i = 0; i < FILL_CODES; i++) begin
         queue_cmd(KIND_BYTE, 128 + ((i * 37) % 128), 0, $urandom);
         queue_cmd(KIND_BYTE, (i % 7) * 31 + (i / 32), $urandom, $urandom);
      end
      for (int i = 0; i < 4; i++) begin
         // Codes already present are reported as duplicates.
         fill_pick = $urandom_range(0, FILL_CODES - 1);
         queue_cmd(KIND_BYTE, 128 + ((fill_pick * 37) % 128), 0, $urandom);
         queue_cmd(KIND_BYTE, (fill_pick % 7) * 31 + (fill_pick / 32), 0, $urandom);
      end
      queue_cmd(KIND_READ, $urandom, $urandom, FILL_CODES);
      queue_cmd(KIND_READ, $urandom, $urandom, FILL_CODES - 1);
      queue_cmd(KIND_READ, $urandom, $urandom, 0);
      for (int i = 0; i < 8; i++) begin
         queue_cmd(KIND_READ, $urandom, $urandom, $urandom_range(0, 2 * FILL_CODES));
      end
      queue_cmd(KIND_UNUSED, $urandom, $urandom, $urandom);
      queue_cmd(KIND_BYTE, 'hC3, 0, $urandom);
      queue_cmd(KIND_CLEAR, $urandom, $urandom, $urandom);

      queue_random_cmds(160);

      total_cmds = pending_cmds.size();
      hold_start = 2 * total_cmds / 3 + 20;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (pending_cmds.size() > 0 || req_valid || expected_results.size() > 0) begin
         @(posedge clock);
      end
      repeat (16) @(posedge clock);

      if (fail_count == 0 && expected_results.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #2000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
